/* design/rcrl_pkg.sv */
// Package for the resource concurrency rate limiter.
// Holds sizes, op codes, state machine type and the front-to-back item struct.
`timescale 1ns / 1ps
`default_nettype none
package rcrl_pkg;

    localparam int NUM_RESOURCES = 32;
    localparam int NUM_CHANNELS  = 64;
    localparam int RES_W   = 5;
    localparam int CH_W    = 6;
    localparam int CNT_W   = 16;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 17;
    localparam int OP_W    = 3;
    localparam int IDX_W   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int CHI_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE     = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_RELEASE_ALL = 3'd2,
        OP_QUERY       = 3'd3,
        OP_SWEEP       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ACT_QUERY,
        ACT_ACQUIRE,
        ACT_RELEASE,
        ACT_SWEEP
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_APPLY,
        ST_WALK,
        ST_REPORT,
        ST_OUT
    } state_t;

    typedef struct packed {
        act_t                      act;
        logic                      all;
        logic [CH_W-1:0]           channel;
        logic [RES_W-1:0]          resource;
        logic                      res_ok;
        logic signed [LIMIT_W-1:0] limit;
        logic [CNT_W-1:0]          window;
        logic [TIME_W-1:0]         now;
    } job_t;

    function automatic logic expired(input logic [TIME_W-1:0] start,
                                     input logic [TIME_W-1:0] now,
                                     input logic [CNT_W-1:0] len);
        logic signed [TIME_W+1:0] rhs;
        begin
            rhs = $signed({2'b00, now}) - $signed({{(TIME_W-CNT_W+2){1'b0}}, len});
            expired = $signed({2'b00, start}) <= rhs;
        end
    endfunction

endpackage
`default_nettype wire

/* design/resource_concurrency_rate_limiter.sv */
// Top level of the resource concurrency rate limiter.
// Depends on rcrl_pkg, rcrl_front and rcrl_back.
//
// channel   handshake      fields
// input     push / full    op, channel_id, resource_id, limit_value,
//                          window_seconds, now_seconds
// result    pop / empty    verdict, total_count, rate_count
//
// Query passes read and report, acquire passes read, apply and report; release one
// walks its own entry, release all and sweep walk all entries, one entry per cycle.
// A two-item queue takes items, until full, while the back part works or stalls.
// Reset clears all entries and holds at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module resource_concurrency_rate_limiter
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [rcrl_pkg::OP_W-1:0]           op,
    input  wire logic [rcrl_pkg::CH_W-1:0]           channel_id,
    input  wire logic [rcrl_pkg::RES_W-1:0]          resource_id,
    input  wire logic signed [rcrl_pkg::LIMIT_W-1:0] limit_value,
    input  wire logic [rcrl_pkg::CNT_W-1:0]          window_seconds,
    input  wire logic [rcrl_pkg::TIME_W-1:0]         now_seconds,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic                                     verdict,
    output logic [rcrl_pkg::CNT_W-1:0]               total_count,
    output logic [rcrl_pkg::CNT_W-1:0]               rate_count
);
    logic           job_valid;
    logic           job_take;
    rcrl_pkg::job_t job;

    rcrl_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .channel_id(channel_id), .resource_id(resource_id),
        .limit_value(limit_value), .window_seconds(window_seconds),
        .now_seconds(now_seconds), .job_valid(job_valid), .job_take(job_take),
        .job(job)
    );

    rcrl_back u_back
    (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_take(job_take),
        .job(job), .empty(empty), .pop(pop), .verdict(verdict),
        .total_count(total_count), .rate_count(rate_count)
    );
endmodule
`default_nettype wire

/* design/rcrl_front.sv */
// Front part: accepts items, classifies them, and feeds a two-entry job queue.
// Depends on rcrl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcrl_front
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic [rcrl_pkg::OP_W-1:0]              op,
    input  wire logic [rcrl_pkg::CH_W-1:0]              channel_id,
    input  wire logic [rcrl_pkg::RES_W-1:0]             resource_id,
    input  wire logic signed [rcrl_pkg::LIMIT_W-1:0]    limit_value,
    input  wire logic [rcrl_pkg::CNT_W-1:0]             window_seconds,
    input  wire logic [rcrl_pkg::TIME_W-1:0]            now_seconds,
    output logic                                        job_valid,
    input  wire logic                                   job_take,
    output rcrl_pkg::job_t                              job
);
    rcrl_pkg::job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    rcrl_pkg::job_t cls;
    logic ch_ok;
    logic r_ok;
    logic do_push;
    logic do_pop;

    always_comb
    begin
        ch_ok = 32'(channel_id) < rcrl_pkg::NUM_CHANNELS;
        r_ok  = 32'(resource_id) < rcrl_pkg::NUM_RESOURCES;
        cls.channel  = channel_id;
        cls.resource = resource_id;
        cls.res_ok   = r_ok;
        cls.limit    = limit_value;
        cls.window   = window_seconds;
        cls.now      = now_seconds;
        cls.all      = 1'b0;
        cls.act      = rcrl_pkg::ACT_QUERY;
        case (op)
            rcrl_pkg::OP_ACQUIRE:
                if (ch_ok && r_ok) cls.act = rcrl_pkg::ACT_ACQUIRE;
            rcrl_pkg::OP_RELEASE:
                if (ch_ok && r_ok) cls.act = rcrl_pkg::ACT_RELEASE;
            rcrl_pkg::OP_RELEASE_ALL:
                if (ch_ok)
                begin
                    cls.act = rcrl_pkg::ACT_RELEASE;
                    cls.all = 1'b1;
                end
            rcrl_pkg::OP_SWEEP:
                cls.act = rcrl_pkg::ACT_SWEEP;
            default:
                cls.act = rcrl_pkg::ACT_QUERY;
        endcase
    end

    assign full      = cnt_reg[1];
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (do_push) wr_reg <= !wr_reg;
            if (do_pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule
`default_nettype wire

/* design/rcrl_back.sv */
// Back part: sequencer that carries out jobs on the entry table and channel holds.
// Depends on rcrl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcrl_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        job_valid,
    output logic                             job_take,
    input  wire rcrl_pkg::job_t              job,
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             verdict,
    output logic [rcrl_pkg::CNT_W-1:0]       total_count,
    output logic [rcrl_pkg::CNT_W-1:0]       rate_count
);
    localparam int NR = rcrl_pkg::NUM_RESOURCES;
    localparam int CW = rcrl_pkg::CNT_W;

    rcrl_pkg::state_t state_reg, state_next;
    logic [NR-1:0]              valid_reg;
    logic [CW-1:0]              use_reg   [NR];
    logic [CW-1:0]              wcnt_reg  [NR];
    logic [rcrl_pkg::TIME_W-1:0] wstart_reg [NR];
    logic [CW-1:0]              wlen_reg  [NR];
    // one word per resource, one bit per channel
    logic [rcrl_pkg::NUM_CHANNELS-1:0] holds_reg [NR];
    rcrl_pkg::job_t             job_reg;
    logic [rcrl_pkg::IDX_W-1:0] k_reg;
    logic                       verdict_reg;
    logic [CW-1:0]              tot_reg;
    logic [CW-1:0]              rate_reg;
    logic                       out_valid_reg;

    logic [rcrl_pkg::IDX_W-1:0]  ri;
    logic [rcrl_pkg::CHI_W-1:0]  ci;
    logic [rcrl_pkg::IDX_W-1:0]  wi;
    logic last;

    assign ri   = job_reg.resource[rcrl_pkg::IDX_W-1:0];
    assign ci   = job_reg.channel[rcrl_pkg::CHI_W-1:0];
    assign wi   = (job_reg.act == rcrl_pkg::ACT_RELEASE && !job_reg.all) ? ri : k_reg;
    assign last = (job_reg.act == rcrl_pkg::ACT_RELEASE && !job_reg.all)
                  || 32'(k_reg) == NR - 1;

    assign empty       = !out_valid_reg;
    assign verdict     = verdict_reg;
    assign total_count = tot_reg;
    assign rate_count  = rate_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcrl_pkg::ST_IDLE:
                if (job_valid) state_next = rcrl_pkg::ST_READ;
            rcrl_pkg::ST_READ:
                case (job_reg.act)
                    rcrl_pkg::ACT_ACQUIRE: state_next = rcrl_pkg::ST_APPLY;
                    rcrl_pkg::ACT_RELEASE,
                    rcrl_pkg::ACT_SWEEP:   state_next = rcrl_pkg::ST_WALK;
                    default:               state_next = rcrl_pkg::ST_REPORT;
                endcase
            rcrl_pkg::ST_APPLY:
                state_next = rcrl_pkg::ST_REPORT;
            rcrl_pkg::ST_WALK:
                if (last) state_next = rcrl_pkg::ST_REPORT;
            rcrl_pkg::ST_REPORT:
                state_next = rcrl_pkg::ST_OUT;
            rcrl_pkg::ST_OUT:
                if (pop) state_next = rcrl_pkg::ST_IDLE;
            default:
                state_next = rcrl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_take = state_reg == rcrl_pkg::ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcrl_pkg::ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            for (int r = 0; r < NR; r++)
            begin
                holds_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                rcrl_pkg::ST_IDLE:
                begin
                    k_reg <= '0;
                end
                rcrl_pkg::ST_READ:
                begin
                    verdict_reg  <= 1'b0;
                    if (job_reg.act == rcrl_pkg::ACT_ACQUIRE && !valid_reg[ri])
                    begin
                        valid_reg[ri]  <= 1'b1;
                        use_reg[ri]    <= '0;
                        wcnt_reg[ri]   <= '0;
                        wstart_reg[ri] <= '0;
                        wlen_reg[ri]   <= '0;
                    end
                end
                rcrl_pkg::ST_APPLY:
                begin
                    logic inc;
                    logic deny;
                    logic [CW-1:0] wc;
                    logic signed [CW+1:0] cmp;
                    inc  = !holds_reg[ri][ci];
                    deny = 1'b0;
                    wc   = wcnt_reg[ri];
                    cmp  = $signed({2'b00, use_reg[ri]}) + $signed({{(CW+1){1'b0}}, inc});
                    if (job_reg.window != '0)
                    begin
                        wlen_reg[ri] <= job_reg.window;
                        if (rcrl_pkg::expired(wstart_reg[ri], job_reg.now, job_reg.window))
                        begin
                            wcnt_reg[ri]   <= CW'(1);
                            wstart_reg[ri] <= job_reg.now;
                        end
                        else
                        begin
                            if (wc != rcrl_pkg::CNT_MAX) wc = wc + 1'b1;
                            wcnt_reg[ri] <= wc;
                            deny = !job_reg.limit[rcrl_pkg::LIMIT_W-1]
                                   && $signed({2'b00, wc}) > $signed({1'b0, job_reg.limit});
                        end
                    end
                    else
                    begin
                        deny = !job_reg.limit[rcrl_pkg::LIMIT_W-1]
                               && cmp > $signed({1'b0, job_reg.limit});
                    end
                    verdict_reg <= deny;
                    if (!deny && inc)
                    begin
                        if (use_reg[ri] != rcrl_pkg::CNT_MAX) use_reg[ri] <= use_reg[ri] + 1'b1;
                        holds_reg[ri][ci] <= 1'b1;
                    end
                end
                rcrl_pkg::ST_WALK:
                begin
                    logic [CW-1:0] u;
                    logic [CW-1:0] w;
                    logic act;
                    u   = use_reg[wi];
                    w   = wcnt_reg[wi];
                    act = 1'b0;
                    if (job_reg.act == rcrl_pkg::ACT_SWEEP)
                    begin
                        if (valid_reg[wi])
                        begin
                            act = 1'b1;
                            if (w != '0 && rcrl_pkg::expired(wstart_reg[wi], job_reg.now,
                                                             wlen_reg[wi]))
                            begin
                                w = '0;
                            end
                        end
                    end
                    else if (holds_reg[wi][ci])
                    begin
                        holds_reg[wi][ci] <= 1'b0;
                        if (valid_reg[wi])
                        begin
                            act = 1'b1;
                            if (u != '0) u = u - 1'b1;
                        end
                    end
                    if (act)
                    begin
                        if (u == '0 && w == '0)
                        begin
                            valid_reg[wi]  <= 1'b0;
                            wstart_reg[wi] <= '0;
                            wlen_reg[wi]   <= '0;
                        end
                        use_reg[wi]  <= u;
                        wcnt_reg[wi] <= w;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                rcrl_pkg::ST_REPORT:
                begin
                    out_valid_reg <= 1'b1;
                    if (job_reg.res_ok && valid_reg[ri])
                    begin
                        tot_reg  <= use_reg[ri];
                        rate_reg <= wcnt_reg[ri];
                    end
                    else
                    begin
                        tot_reg  <= '0;
                        rate_reg <= '0;
                    end
                end
                rcrl_pkg::ST_OUT:
                    if (pop) out_valid_reg <= 1'b0;
                default:
                    out_valid_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rcrl_pkg::ST_IDLE && job_valid)
        begin
            job_reg <= job;
        end
    end
endmodule
`default_nettype wire

/* design/rcrl_checker.sv */
// Port-level assertions for the resource concurrency rate limiter, bound to the top.
// Depends on rcrl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcrl_props
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          push,
    input wire logic                          full,
    input wire logic                          empty,
    input wire logic                          pop,
    input wire logic                          verdict,
    input wire logic [rcrl_pkg::CNT_W-1:0]    total_count,
    input wire logic [rcrl_pkg::CNT_W-1:0]    rate_count
);
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(total_count) && $stable(rate_count)))
        else $error("result changed while waiting");
    a_verdict_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(verdict))
        else $error("verdict changed while waiting");
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result after reset");
    a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
        else $error("full after reset");
    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("unknown handshake flag");
endmodule

bind resource_concurrency_rate_limiter rcrl_props u_rcrl_props
(
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
    .verdict(verdict), .total_count(total_count), .rate_count(rate_count)
);
`default_nettype wire

/* sim/rcrl_checker.sv */
// Checker for the resource concurrency rate limiter: watches both queues,
// predicts each result from its own copy of the admission table and compares.
// Depends on rcrl_pkg.
`timescale 1ns / 1ps
module rcrl_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic [rcrl_pkg::OP_W-1:0]           op,
    input  logic [rcrl_pkg::CH_W-1:0]           channel_id,
    input  logic [rcrl_pkg::RES_W-1:0]          resource_id,
    input  logic signed [rcrl_pkg::LIMIT_W-1:0] limit_value,
    input  logic [rcrl_pkg::CNT_W-1:0]          window_seconds,
    input  logic [rcrl_pkg::TIME_W-1:0]         now_seconds,
    input  logic                                empty,
    input  logic                                pop,
    input  logic                                verdict,
    input  logic [rcrl_pkg::CNT_W-1:0]          total_count,
    input  logic [rcrl_pkg::CNT_W-1:0]          rate_count,
    output int                                  errors,
    output int                                  pending
);
    import rcrl_pkg::*;

    typedef struct packed {
        logic             deny;
        logic [CNT_W-1:0] uses;
        logic [CNT_W-1:0] rate;
    } answer_t;

    logic                     live  [NUM_RESOURCES];
    logic [CNT_W-1:0]         uses  [NUM_RESOURCES];
    logic [CNT_W-1:0]         rate  [NUM_RESOURCES];
    logic [TIME_W-1:0]        start [NUM_RESOURCES];
    logic [CNT_W-1:0]         span  [NUM_RESOURCES];
    logic [NUM_RESOURCES-1:0] holds [NUM_CHANNELS];
    answer_t                  answers[$];

    assign pending = answers.size();

    function automatic logic lapsed(logic [TIME_W-1:0] s, logic [TIME_W-1:0] t,
                                    logic [CNT_W-1:0] len);
        longint lhs;
        longint rhs;
        begin
            lhs = longint'(s);
            rhs = longint'(t) - longint'(len);
            return lhs <= rhs;
        end
    endfunction

    task automatic wipe(int r);
        live[r] = 0; uses[r] = 0; rate[r] = 0; start[r] = 0; span[r] = 0;
    endtask

    task automatic drop(int c, int r);
        if (holds[c][r])
        begin
            holds[c][r] = 0;
            if (live[r])
            begin
                if (uses[r] > 0)
                    uses[r]--;
                if (uses[r] == 0 && rate[r] == 0)
                    wipe(r);
            end
        end
    endtask

    task automatic admit(logic [OP_W-1:0] o, int c, int r, logic signed [LIMIT_W-1:0] lim,
                         logic [CNT_W-1:0] win, logic [TIME_W-1:0] t);
        answer_t a;
        logic    inc;
        begin
            a = '0;
            if (o == OP_ACQUIRE)
            begin
                inc = !holds[c][r];
                if (!live[r])
                begin
                    wipe(r);
                    live[r] = 1;
                end
                if (win > 0)
                begin
                    span[r] = win;
                    if (lapsed(start[r], t, win))
                    begin
                        rate[r] = 1;
                        start[r] = t;
                    end
                    else
                    begin
                        if (rate[r] != '1)
                            rate[r]++;
                        if (lim >= 0 && int'(rate[r]) > int'(lim))
                            a.deny = 1;
                    end
                end
                else if (lim >= 0 && int'(uses[r]) + int'(inc) > int'(lim))
                    a.deny = 1;
                if (!a.deny && inc)
                begin
                    if (uses[r] != '1)
                        uses[r]++;
                    holds[c][r] = 1;
                end
            end
            else if (o == OP_RELEASE)
                drop(c, r);
            else if (o == OP_RELEASE_ALL)
            begin
                for (int k = 0; k < NUM_RESOURCES; k++)
                    drop(c, k);
            end
            else if (o == OP_SWEEP)
            begin
                for (int k = 0; k < NUM_RESOURCES; k++)
                begin
                    if (live[k])
                    begin
                        if (rate[k] > 0 && lapsed(start[k], t, span[k]))
                            rate[k] = 0;
                        if (uses[k] == 0 && rate[k] == 0)
                            wipe(k);
                    end
                end
            end
            if (live[r])
            begin
                a.uses = uses[r];
                a.rate = rate[r];
            end
            answers.push_back(a);
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        for (int r = 0; r < NUM_RESOURCES; r++)
            wipe(r);
        for (int c = 0; c < NUM_CHANNELS; c++)
            holds[c] = '0;
    end

    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && pop && !empty)
        begin
            if (answers.size() == 0)
                report("unexpected item", 0, 0);
            else
            begin
                a = answers.pop_front();
                if (verdict !== a.deny)
                    report("verdict", verdict, a.deny);
                if (total_count !== a.uses)
                    report("total_count", total_count, a.uses);
                if (rate_count !== a.rate)
                    report("rate_count", rate_count, a.rate);
            end
        end
        if (rst_n && push && !full)
            admit(op, channel_id, resource_id, limit_value, window_seconds, now_seconds);
    end
endmodule

/* sim/tb_resource_concurrency_rate_limiter.sv */
// Testbench top for the resource concurrency rate limiter: directed and random
// items with random idling on both sides; verdict from rcrl_checker.
// Depends on rcrl_pkg, rcrl_checker and the block.
`timescale 1ns / 1ps
module tb_resource_concurrency_rate_limiter;
    import rcrl_pkg::*;

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic [OP_W-1:0]             op;
    logic [CH_W-1:0]             channel_id;
    logic [RES_W-1:0]            resource_id;
    logic signed [LIMIT_W-1:0]   limit_value;
    logic [CNT_W-1:0]            window_seconds;
    logic [TIME_W-1:0]           now_seconds;
    logic                        empty;
    logic                        pop;
    logic                        verdict;
    logic [CNT_W-1:0]            total_count;
    logic [CNT_W-1:0]            rate_count;
    int                          errors;
    int                          pending;
    int                          quiet;
    bit                          hold_pop;
    bit                          sent_all;
    logic [TIME_W-1:0]           clock_now;

    resource_concurrency_rate_limiter dut (.*);

    rcrl_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // called at a falling edge; push stays high after the accepting edge
    task automatic offer(logic [OP_W-1:0] o, int c, int r, int lim, int win,
                         logic [TIME_W-1:0] t);
        int gap;
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                push <= 0;
                repeat (gap) @(negedge clk);
            end
            push <= 1;
            op <= o; channel_id <= c; resource_id <= r;
            limit_value <= lim; window_seconds <= win; now_seconds <= t;
            @(posedge clk);
            while (full)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic random_item();
        int o;
        int lim;
        int win;
        begin
            o = $urandom_range(0, 99);
            o = o < 55 ? OP_ACQUIRE : o < 75 ? OP_RELEASE : o < 82 ? OP_RELEASE_ALL :
                o < 90 ? OP_QUERY : o < 95 ? OP_SWEEP : $urandom_range(5, 7);
            case ($urandom_range(0, 5))
                0: lim = -1;
                1: lim = -int'($urandom_range(1, 65536));
                2: lim = $urandom_range(0, 65535);
                default: lim = $urandom_range(0, 4);
            endcase
            win = $urandom_range(0, 2) == 0 ? 0 :
                  $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 20);
            if ($urandom_range(0, 30) == 0)
                clock_now = $urandom;
            else
                clock_now = clock_now + $urandom_range(0, 3);
            offer(o, $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 5),
                  $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 3),
                  lim, win, clock_now);
        end
    endtask

    initial
    begin
        push = 0; op = OP_QUERY; channel_id = 0; resource_id = 0;
        limit_value = 0; window_seconds = 0; now_seconds = 0;
        sent_all = 0; hold_pop = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        offer(OP_QUERY, 0, 0, 0, 0, 0);
        offer(OP_ACQUIRE, 0, 0, 1, 0, 0);
        offer(OP_ACQUIRE, 0, 0, 1, 0, 0);
        offer(OP_ACQUIRE, 1, 0, 1, 0, 0);
        offer(OP_ACQUIRE, 63, 31, -1, 0, 32'hFFFF_FFFF);
        offer(OP_ACQUIRE, 62, 31, -65536, 65535, 32'hFFFF_FFFF);
        offer(OP_ACQUIRE, 5, 31, 65535, 65535, 32'hFFFF_FFFE);
        offer(OP_ACQUIRE, 2, 3, 1, 10, 5);
        offer(OP_ACQUIRE, 3, 3, 1, 10, 6);
        offer(OP_ACQUIRE, 4, 3, 0, 10, 100);
        offer(OP_QUERY, 4, 3, 0, 0, 0);
        offer(OP_RELEASE, 1, 0, 0, 0, 0);
        offer(OP_RELEASE, 0, 0, 0, 0, 0);
        offer(OP_RELEASE, 0, 0, 0, 0, 0);
        offer(OP_RELEASE_ALL, 63, 31, 0, 0, 0);
        offer(OP_SWEEP, 0, 3, 0, 0, 200);
        offer(OP_SWEEP, 0, 31, 0, 0, 32'hFFFF_FFFF);
        offer(5, 2, 3, 0, 0, 0);
        offer(7, 0, 0, 0, 0, 0);
        offer(OP_RELEASE_ALL, 62, 0, 0, 0, 0);
        clock_now = 1000;
        for (int i = 0; i < 1400; i++)
        begin
            if (i == 300)
            begin
                hold_pop = 1;
                for (int j = 0; j < 10; j++)
                    random_item();
                hold_pop = 0;
            end
            if (i == 700)
            begin
                push <= 0;
                do
                    @(negedge clk);
                while (pending != 0);
            end
            random_item();
        end
        push <= 0;
        sent_all = 1;
    end

    initial
    begin
        int wait_n;
        pop = 0;
        forever
        begin
            @(negedge clk);
            if (hold_pop)
            begin
                pop <= 0;
                repeat (200) @(negedge clk);
            end
            wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
            pop <= 0;
            repeat (wait_n) @(negedge clk);
            pop <= 1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    initial
    begin
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
            if (sent_all && pending == 0)
            begin
                repeat (60) @(posedge clk);
                if (errors == 0 && pending == 0)
                    $display("*** PASSED ***");
                else
                    $display("*** FAILED ***");
                $finish;
            end
            if (quiet > 5000)
            begin
                $display("timeout");
                $display("*** FAILED ***");
                $finish;
            end
        end
    end
endmodule
